FILE: hw/rtl/hno_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hno_pkg
// Types and constants shared by the hexagon neighbour ordering block.
// ----------------------------------------------------------------------------
package hno_pkg;

    localparam int NUM_CORNERS = 6;
    localparam logic [2:0] LAST_CORNER = 3'd5;

    localparam logic [15:0] RADIUS_RESET = 16'd256;
    localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
    localparam logic [31:0] ROUND_HALF_Q16 = 32'd32768;

    localparam logic signed [21:0] Q20_MAX = 22'sd524287;
    localparam logic signed [21:0] Q20_MIN = -22'sd524288;

    typedef enum logic [1:0] {
        MAG_ZERO,
        MAG_HALF,
        MAG_SQRT3,
        MAG_ONE
    } t_mag;

    // Sine and cosine magnitude codes and sign bits for corner k at k*60 degrees.
    localparam t_mag SIN_MAG [NUM_CORNERS] =
        '{MAG_ZERO, MAG_SQRT3, MAG_SQRT3, MAG_ZERO, MAG_SQRT3, MAG_SQRT3};
    localparam t_mag COS_MAG [NUM_CORNERS] =
        '{MAG_ONE, MAG_HALF, MAG_HALF, MAG_ONE, MAG_HALF, MAG_HALF};
    localparam logic [NUM_CORNERS-1:0] SIN_NEG = 6'b110000;
    localparam logic [NUM_CORNERS-1:0] COS_NEG = 6'b011100;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POINT,
        ST_CELL,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       start;
        logic       point;
        logic       lookup;
        logic       check;
        logic       clr;
        logic       load_out;
        logic [2:0] corner;
        logic [2:0] slot;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       out_free;
        logic [2:0] count;
    } t_sts;

endpackage

FILE: hw/rtl/hno_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hno_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hno_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/hno_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hno_ctrl
// Sequencer: map clearing, three steps per corner, then result transfers.
// ----------------------------------------------------------------------------
module hno_ctrl
    import hno_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_k, n_k;
    logic [2:0] r_e, n_e;
    logic       w_accept;
    logic       w_emit_last;

    assign w_accept = i_s_tvalid && (r_state == ST_IDLE);
    assign w_emit_last = (i_sts.count == 3'd0) || (r_e == i_sts.count - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= 3'd0;
            r_e     <= 3'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_e     <= n_e;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_e     = r_e;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_POINT;
                    n_k     = 3'd0;
                end
            end
            ST_POINT: begin
                n_state = ST_CELL;
            end
            ST_CELL: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_k == LAST_CORNER) begin
                    n_state = ST_EMIT;
                    n_e     = 3'd0;
                end else begin
                    n_state = ST_POINT;
                    n_k     = r_k + 3'd1;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    if (w_emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_e = r_e + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.corner = r_k;
        o_cmd.slot   = r_e;
        o_s_tready   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.start = w_accept;
            end
            ST_POINT: begin
                o_cmd.point = 1'b1;
            end
            ST_CELL: begin
                o_cmd.lookup = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/hno_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hno_datapath
// Corner arithmetic, visited map, sorted free list and output register.
// ----------------------------------------------------------------------------
module hno_datapath
    import hno_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser,
    input  t_cmd        i_cmd,
    output t_sts        o_sts
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int VW     = 22 + $clog2(GRID_SIDE);
    localparam int QW     = VW - 8;
    localparam logic signed [VW-1:0] GS = VW'(GRID_SIDE);
    localparam logic [QW-1:0] CELLS_Q = QW'(CELLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic signed [VW-1:0] V_LOW = -VW'(256);

    logic [15:0]              r_radius;
    logic [15:0]              r_mag_s;
    logic signed [19:0]       r_cx, r_cy, r_rx, r_ry;
    logic                     r_have;
    logic signed [19:0]       r_px, r_py;
    logic [ADDR_W-1:0]        r_addr;
    logic                     r_inr;
    logic [41:0]              r_dx2, r_dy2;
    logic [ADDR_W-1:0]        r_clr;
    logic [2:0]               r_n;
    logic [42:0]              r_sd [NUM_CORNERS];
    logic [2:0]               r_sk [NUM_CORNERS];
    logic signed [19:0]       r_sx [NUM_CORNERS];
    logic signed [19:0]       r_sy [NUM_CORNERS];
    logic                     r_ov;
    logic [47:0]              r_odata;
    logic                     r_olast;
    logic                     r_ofound;

    logic [31:0]              w_prod;
    logic [15:0]              w_mag_h;
    logic signed [16:0]       w_off_x, w_off_y;
    logic signed [21:0]       w_sum_x, w_sum_y;
    logic signed [VW-1:0]     w_xe, w_ye, w_v;
    logic [QW-1:0]            w_vq;
    logic [ADDR_W-1:0]        w_raddr;
    logic                     w_inr;
    logic signed [20:0]       w_dx, w_dy;
    logic signed [41:0]       w_sqx, w_sqy;
    logic                     w_rdata;
    logic                     w_free;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [42:0]              w_dist;
    logic [NUM_CORNERS-1:0]   w_gt;
    logic [42:0]              n_sd [NUM_CORNERS];
    logic [2:0]               n_sk [NUM_CORNERS];
    logic signed [19:0]       n_sx [NUM_CORNERS];
    logic signed [19:0]       n_sy [NUM_CORNERS];

    function automatic logic signed [16:0] f_offset(
        input t_mag        mag,
        input logic        neg,
        input logic [15:0] r,
        input logic [15:0] h,
        input logic [15:0] s
    );
        logic [15:0] m;
        case (mag)
            MAG_ZERO:  m = 16'd0;
            MAG_HALF:  m = h;
            MAG_SQRT3: m = s;
            MAG_ONE:   m = r;
            default:   m = 16'd0;
        endcase
        return neg ? -signed'({1'b0, m}) : signed'({1'b0, m});
    endfunction

    function automatic logic signed [19:0] f_sat(input logic signed [21:0] v);
        if (v > Q20_MAX) begin
            return 20'sh7FFFF;
        end else if (v < Q20_MIN) begin
            return 20'sh80000;
        end
        return v[19:0];
    endfunction

    // Offset magnitudes: full radius, radius/2 and radius*sqrt(3)/2, rounded half up.
    assign w_prod  = (r_radius * SQRT3_HALF_Q16[15:0]) + ROUND_HALF_Q16;
    assign w_mag_h = 16'(({1'b0, r_radius} + 17'd1) >> 1);

    assign w_off_x = f_offset(SIN_MAG[i_cmd.corner], SIN_NEG[i_cmd.corner],
                              r_radius, w_mag_h, r_mag_s);
    assign w_off_y = f_offset(COS_MAG[i_cmd.corner], COS_NEG[i_cmd.corner],
                              r_radius, w_mag_h, r_mag_s);
    assign w_sum_x = r_cx + w_off_x;
    assign w_sum_y = r_cy + w_off_y;

    // Cell index is x + side*y in Q.8, truncated toward zero.
    assign w_xe    = r_px;
    assign w_ye    = r_py;
    assign w_v     = w_xe + w_ye * GS;
    assign w_vq    = w_v[VW-1:8];
    assign w_inr   = (w_v > V_LOW) && (w_v[VW-1] || (w_vq < CELLS_Q));
    assign w_raddr = w_v[VW-1] ? '0 : w_vq[ADDR_W-1:0];

    assign w_dx  = r_px - r_rx;
    assign w_dy  = r_py - r_ry;
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;

    assign w_free  = i_cmd.check && r_inr && !w_rdata;
    assign w_we    = i_cmd.clr || w_free;
    assign w_waddr = i_cmd.clr ? r_clr : r_addr;
    assign w_dist  = {1'b0, r_dx2} + {1'b0, r_dy2};

    hno_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (!i_cmd.clr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Stable insertion: the new entry goes in front of the first strictly larger one.
    always_comb begin
        for (int j = 0; j < NUM_CORNERS; j++) begin
            w_gt[j] = (3'(j) < r_n) && (r_sd[j] > w_dist);
        end
        for (int j = 0; j < NUM_CORNERS; j++) begin
            if (w_gt[j] || (3'(j) == r_n)) begin
                n_sd[j] = w_dist;
                n_sk[j] = i_cmd.corner;
                n_sx[j] = r_px;
                n_sy[j] = r_py;
            end else begin
                n_sd[j] = r_sd[j];
                n_sk[j] = r_sk[j];
                n_sx[j] = r_sx[j];
                n_sy[j] = r_sy[j];
            end
        end
        for (int j = 1; j < NUM_CORNERS; j++) begin
            if (w_gt[j-1]) begin
                n_sd[j] = r_sd[j-1];
                n_sk[j] = r_sk[j-1];
                n_sx[j] = r_sx[j-1];
                n_sy[j] = r_sy[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_rx     <= '0;
            r_ry     <= '0;
            r_have   <= 1'b0;
            r_clr    <= '0;
            r_n      <= 3'd0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.start) begin
                r_n <= 3'd0;
                if (!r_have) begin
                    r_rx   <= signed'(i_s_tdata[19:0]);
                    r_ry   <= signed'(i_s_tdata[39:20]);
                    r_have <= 1'b1;
                end
            end
            if (w_free) begin
                r_n <= r_n + 3'd1;
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_s <= w_prod[31:16];
        if (i_cmd.start) begin
            r_cx <= signed'(i_s_tdata[19:0]);
            r_cy <= signed'(i_s_tdata[39:20]);
        end
        if (i_cmd.point) begin
            r_px <= f_sat(w_sum_x);
            r_py <= f_sat(w_sum_y);
        end
        if (i_cmd.lookup) begin
            r_addr <= w_raddr;
            r_inr  <= w_inr;
            r_dx2  <= unsigned'(w_sqx);
            r_dy2  <= unsigned'(w_sqy);
        end
        if (w_free) begin
            for (int j = 0; j < NUM_CORNERS; j++) begin
                r_sd[j] <= n_sd[j];
                r_sk[j] <= n_sk[j];
                r_sx[j] <= n_sx[j];
                r_sy[j] <= n_sy[j];
            end
        end
        if (i_cmd.load_out) begin
            if (r_n == 3'd0) begin
                r_odata  <= '0;
                r_ofound <= 1'b0;
                r_olast  <= 1'b1;
            end else begin
                r_odata  <= {5'd0, r_sy[i_cmd.slot], r_sx[i_cmd.slot], r_sk[i_cmd.slot]};
                r_ofound <= 1'b1;
                r_olast  <= (i_cmd.slot == r_n - 3'd1);
            end
        end
    end

    assign o_sts.clr_done = (r_clr == LAST_ADDR);
    assign o_sts.out_free = !r_ov || i_m_tready;
    assign o_sts.count    = r_n;

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ofound;

endmodule

FILE: hw/rtl/hex_neighbour_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_neighbour_order
// Hexagon corner sampler with a visited-cell filter and distance ordering.
// ----------------------------------------------------------------------------
// Each input is handled in three steps per corner (point, cell lookup, check),
// then its results (1 to 6) are sent; no new input is taken until the last
// result has been loaded into the output register.
// Reset: synchronous active low; the visited map is then cleared one cell a
// cycle, all GRID_SIDE*GRID_SIDE cells (4096 by default), before input is taken.
module hex_neighbour_order
    import hno_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // radius
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,     // center_x, center_y
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,     // neighbour_index, point_x, point_y, zero fill
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser      // found
);

    t_cmd w_cmd;
    t_sts w_sts;

    hno_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hno_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

FILE: hw/rtl/hno_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hno_checker
// Port-level checks of the hexagon neighbour ordering block.
// ----------------------------------------------------------------------------
module hno_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [0:0]  o_m_tuser
);

    // A stalled result transfer keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // A result without a free corner is alone, final and all zero.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast && (o_m_tdata == 48'd0))
        else $error("malformed none-free result");

    // Corner numbers stay within the hexagon.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata[2:0] != 3'd6) && (o_m_tdata[2:0] != 3'd7))
        else $error("corner number out of range");

    // One input is worked on at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

endmodule

bind hex_neighbour_order hno_checker u_hno_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hex_neighbour_order. A short table of directed
// centres, then several random phases under different radius settings, are
// streamed in with bursty input and a stalling output. Every centre goes
// through a local model of the hexagon corners, the visited-cell map and the
// distance ordering, and each output transfer is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int GRID_SIDE = 64;
    localparam int MAP_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CLK_HALF = 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int HOLD_PHASE = 2;
    localparam int NO_GAP_PHASE = 3;

    typedef enum logic [1:0] {
        ROW_SET_RADIUS,
        ROW_PREDICT,
        ROW_NONE_FREE,
        ROW_ORIGIN
    } t_row_kind;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    typedef struct {
        t_row_kind          kind;
        logic signed [19:0] cx;
        logic signed [19:0] cy;
    } t_center_row;

    typedef struct {
        logic [2:0]         corner;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic               found;
        logic               last;
    } t_corner_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic [39:0] i_s_tdata = '0;    // center_x, center_y
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;         // neighbour_index, point_x, point_y, zero fill
    logic        o_m_tlast;
    logic [0:0]  o_m_tuser;         // found

    // Model state.
    logic [15:0]        hex_radius = 16'd256;
    logic signed [19:0] origin_x = '0;
    logic signed [19:0] origin_y = '0;
    bit                 origin_set = 1'b0;
    bit                 map_marked [MAP_CELLS];
    t_corner_result     ranked [6];
    int                 ranked_n;

    t_corner_result expected_q [$];
    t_center_row    directed_rows [$];

    int       mismatches = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    bit       no_gaps = 1'b0;
    t_rx_mode rx_mode = RX_RANDOM;
    bit       hold_request = 1'b0;
    int       hold_left = 0;
    int       rx_cycle = 0;

    hex_neighbour_order #(
        .GRID_SIDE(GRID_SIDE)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast),
        .o_m_tuser(o_m_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Signed Q1.16 sine and cosine of k*60 degrees.
    function automatic int sin_q16(int k);
        case (k)
            1, 2: return 56756;
            4, 5: return -56756;
            default: return 0;
        endcase
    endfunction

    function automatic int cos_q16(int k);
        case (k)
            0: return 65536;
            1, 5: return 32768;
            2, 4: return -32768;
            default: return -65536;
        endcase
    endfunction

    function automatic longint scaled_offset(int trig);
        longint mag;
        longint o;
        mag = (trig < 0) ? -trig : trig;
        o = (longint'(hex_radius) * mag + 32768) >>> 16;
        return (trig < 0) ? -o : o;
    endfunction

    function automatic logic signed [19:0] clamp20(longint v);
        if (v < -524288) return -20'sd524288;
        if (v > 524287) return 20'sd524287;
        return v[19:0];
    endfunction

    function automatic bit claim_cell(longint x, longint y);
        longint v;
        longint cell_id;
        v = x + GRID_SIDE * y;
        cell_id = v / 256;
        if (cell_id < 0 || cell_id >= MAP_CELLS) return 1'b0;
        if (map_marked[cell_id]) return 1'b0;
        map_marked[cell_id] = 1'b1;
        return 1'b1;
    endfunction

    task automatic rank_free_corners(input logic signed [19:0] cx,
                                     input logic signed [19:0] cy);
        logic signed [19:0] px [6];
        logic signed [19:0] py [6];
        longint dist_sq [6];
        int order [6];
        longint dx, dy, d;
        int n, t, j;
        n = 0;
        if (!origin_set) begin
            origin_x = cx;
            origin_y = cy;
            origin_set = 1'b1;
        end
        for (int k = 0; k < 6; k++) begin
            px[k] = clamp20(longint'(cx) + scaled_offset(sin_q16(k)));
            py[k] = clamp20(longint'(cy) + scaled_offset(cos_q16(k)));
            if (claim_cell(px[k], py[k])) begin
                dx = longint'(px[k]) - longint'(origin_x);
                dy = longint'(py[k]) - longint'(origin_y);
                dist_sq[n] = dx * dx + dy * dy;
                order[n] = k;
                n++;
            end
        end
        // Stable insertion sort, so equal distances keep corner order.
        for (int i = 1; i < n; i++) begin
            d = dist_sq[i];
            t = order[i];
            j = i - 1;
            while (j >= 0 && dist_sq[j] > d) begin
                dist_sq[j + 1] = dist_sq[j];
                order[j + 1] = order[j];
                j--;
            end
            dist_sq[j + 1] = d;
            order[j + 1] = t;
        end
        if (n == 0) begin
            ranked[0].corner = '0;
            ranked[0].px = '0;
            ranked[0].py = '0;
            ranked[0].found = 1'b0;
            ranked[0].last = 1'b1;
            ranked_n = 1;
        end else begin
            for (int i = 0; i < n; i++) begin
                ranked[i].corner = order[i][2:0];
                ranked[i].px = px[order[i]];
                ranked[i].py = py[order[i]];
                ranked[i].found = 1'b1;
                ranked[i].last = (i == n - 1);
            end
            ranked_n = n;
        end
    endtask

    task automatic push_result(input int corner, input int px, input int py,
                               input bit found, input bit last);
        t_corner_result r;
        r.corner = corner[2:0];
        r.px = px[19:0];
        r.py = py[19:0];
        r.found = found;
        r.last = last;
        expected_q = {expected_q, r};
    endtask

    task automatic add_row(input t_row_kind kind, input int x, input int y);
        t_center_row r;
        r.kind = kind;
        r.cx = x[19:0];
        r.cy = y[19:0];
        directed_rows = {directed_rows, r};
    endtask

    task automatic offer_center(input t_row_kind kind, input logic signed [19:0] cx,
                                input logic signed [19:0] cy);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = no_gaps ? 1000 : $urandom_range(1, 16);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {cy, cx};
        do @(posedge i_clk); while (!o_s_tready);
        rank_free_corners(cx, cy);
        case (kind)
            ROW_NONE_FREE: begin
                push_result(0, 0, 0, 1'b0, 1'b1);
            end
            ROW_ORIGIN: begin
                push_result(0, 0, 256, 1'b1, 1'b0);
                push_result(1, 222, 128, 1'b1, 1'b0);
                push_result(5, -222, 128, 1'b1, 1'b1);
            end
            default: begin
                for (int i = 0; i < ranked_n; i++) expected_q = {expected_q, ranked[i]};
            end
        endcase
    endtask

    // Called in the step of the last input transfer, so the valid drop is the
    // only assignment to it in that step.
    task automatic drain_outputs();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hex_radius = value;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_request && hold_left == 0) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_m_tready <= 1'b1;
                RX_RANDOM: i_m_tready <= ($urandom_range(0, 99) < 65);
                default: i_m_tready <= (rx_cycle % 7 != 2) && (rx_cycle % 7 != 5)
                                       && (rx_cycle % 11 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_corner_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                $error("Output transfer with no result expected: tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                check_field("neighbour_index", want.corner, o_m_tdata[2:0]);
                check_field("point_x", want.px, $signed(o_m_tdata[22:3]));
                check_field("point_y", want.py, $signed(o_m_tdata[42:23]));
                check_field("found", want.found, o_m_tuser[0]);
                check_field("last", want.last, o_m_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
        else idle_cycles++;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("hex_neighbour_order verification failed");
        $finish;
    end

    initial begin
        logic signed [19:0] cx, cy;
        int pick;
        for (int i = 0; i < MAP_CELLS; i++) map_marked[i] = 1'b0;

        // The first row runs at the reset radius with the origin at zero.
        add_row(ROW_ORIGIN, 0, 0);
        add_row(ROW_NONE_FREE, 0, 0);
        add_row(ROW_NONE_FREE, -524288, -524288);
        add_row(ROW_NONE_FREE, 524287, 524287);
        add_row(ROW_NONE_FREE, 524287, -524288);
        add_row(ROW_NONE_FREE, -524288, 524287);
        add_row(ROW_PREDICT, -100, 0);
        add_row(ROW_PREDICT, 4000, 8000);
        add_row(ROW_PREDICT, 4200, 8000);
        add_row(ROW_SET_RADIUS, 0, 0);
        add_row(ROW_PREDICT, -50, 0);
        add_row(ROW_NONE_FREE, -50, 0);
        add_row(ROW_SET_RADIUS, 65535, 0);
        add_row(ROW_PREDICT, 0, 0);
        add_row(ROW_PREDICT, 524000, -1000);
        add_row(ROW_PREDICT, 8000, 8000);
        add_row(ROW_SET_RADIUS, 1, 0);
        add_row(ROW_PREDICT, 12000, 12000);
        add_row(ROW_PREDICT, -1, 16383);
        add_row(ROW_PREDICT, 255, 16380);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_SET_RADIUS) begin
                drain_outputs();
                write_radius(directed_rows[r].cx[15:0]);
            end else begin
                offer_center(directed_rows[r].kind, directed_rows[r].cx, directed_rows[r].cy);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_outputs();
            case (phase)
                0: write_radius(16'($urandom_range(128, 1024)));
                1: write_radius(16'($urandom_range(0, 65535)));
                2: write_radius(16'($urandom_range(0, 64)));
                3: write_radius(16'($urandom_range(256, 4096)));
                default: write_radius(16'($urandom_range(0, 65535)));
            endcase
            rx_mode = t_rx_mode'(phase % 3);
            no_gaps = (phase == NO_GAP_PHASE);
            hold_request = (phase == HOLD_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    cx = 20'($urandom_range(0, 20480) - 2048);
                    cy = 20'($urandom_range(0, 18432) - 1024);
                end else if (pick < 87) begin
                    // On the origin's vertical line, mirrored corners tie.
                    cx = origin_x;
                    cy = 20'($urandom_range(0, 16384));
                end else begin
                    cx = 20'($urandom);
                    cy = 20'($urandom);
                end
                offer_center(ROW_PREDICT, cx, cy);
            end
        end

        drain_outputs();
        if (mismatches == 0) begin
            $display("hex_neighbour_order verification clean");
        end else begin
            $display("hex_neighbour_order verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hno_pkg.sv
hw/rtl/hno_ram.sv
hw/rtl/hno_ctrl.sv
hw/rtl/hno_datapath.sv
hw/rtl/hex_neighbour_order.sv
hw/rtl/hno_checker.sv
tb/testbench.sv
